/* rtl/bds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear downscale package
// Widths, register map and the structs shared by the weight and blend stages.
// ----------------------------------------------------------------------------
package bds_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 12;
  localparam int STEP_W    = FRAC_BITS + 2;
  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = PIX_W / CH_W;
  localparam int SRC_W     = 13;
  localparam int POS_W     = COORD_W + STEP_W;
  localparam int OMF_W     = FRAC_BITS + 1;
  localparam int WGT_W     = 2 * FRAC_BITS + 2;
  localparam int PROD_W    = WGT_W + CH_W;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;
  localparam logic [OMF_W-1:0]  ONE_Q      = OMF_W'(1) << FRAC_BITS;
  localparam logic [WGT_W:0]    ONE_SQ     = (WGT_W + 1)'(1) << (2 * FRAC_BITS);

  typedef enum logic [0:0] {
    REG_STEP_X = 1'b0,
    REG_STEP_Y = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [WGT_W-1:0] here;
    logic [WGT_W-1:0] east;
    logic [WGT_W-1:0] south;
    logic [WGT_W-1:0] southeast;
  } wgt_t;

  typedef struct packed {
    logic [PIX_W-1:0] here;
    logic [PIX_W-1:0] east;
    logic [PIX_W-1:0] south;
    logic [PIX_W-1:0] southeast;
  } pix_quad_t;

  typedef struct packed {
    logic [SRC_W-1:0] col;
    logic [SRC_W-1:0] row;
  } src_idx_t;

endpackage
`default_nettype wire

/* rtl/bds_blend.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear blend
// Two stages: per-channel weight products, then sum, truncate and hold the
// output word.
// ----------------------------------------------------------------------------
module bds_blend (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire bds_pkg::wgt_t      wgt_i,
  input  wire bds_pkg::pix_quad_t pix_i,
  input  wire bds_pkg::src_idx_t  idx_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [bds_pkg::PIX_W-1:0] pixel_o,
  output bds_pkg::src_idx_t       idx_o
);
  import bds_pkg::*;

  logic              p_valid_q;
  logic              o_valid_q;
  logic              p_en;
  logic              o_en;
  logic [PROD_W-1:0] prod_d [NUM_CH][4];
  logic [PROD_W-1:0] prod_q [NUM_CH][4];
  src_idx_t          p_idx_q;
  logic [PIX_W-1:0]  pixel_d;
  logic [PIX_W-1:0]  pixel_q;
  src_idx_t          o_idx_q;
  logic [PROD_W-1:0] sum;

  assign o_en    = !o_valid_q || ready_i;
  assign p_en    = !p_valid_q || o_en;
  assign ready_o = p_en;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod_d[k][0] = PROD_W'(pix_i.here[k*CH_W +: CH_W]) * PROD_W'(wgt_i.here);
      prod_d[k][1] = PROD_W'(pix_i.east[k*CH_W +: CH_W]) * PROD_W'(wgt_i.east);
      prod_d[k][2] = PROD_W'(pix_i.south[k*CH_W +: CH_W]) * PROD_W'(wgt_i.south);
      prod_d[k][3] = PROD_W'(pix_i.southeast[k*CH_W +: CH_W])
                     * PROD_W'(wgt_i.southeast);
    end
  end

  always_comb begin
    pixel_d = '0;
    sum     = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      sum = prod_q[k][0] + prod_q[k][1] + prod_q[k][2] + prod_q[k][3];
      pixel_d[k*CH_W +: CH_W] = sum[2*FRAC_BITS +: CH_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (p_en) p_valid_q <= valid_i;
      if (o_en) o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en && valid_i) begin
      prod_q  <= prod_d;
      p_idx_q <= idx_i;
    end
    if (o_en && p_valid_q) begin
      pixel_q <= pixel_d;
      o_idx_q <= p_idx_q;
    end
  end

  assign valid_o = o_valid_q;
  assign pixel_o = pixel_q;
  assign idx_o   = o_idx_q;

`ifndef SYNTH
  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !o_en) |=> (p_valid_q && $stable(p_idx_q)))
    else $error("product stage lost its word while stalled");

  a_out_from_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_valid_q) |-> $past(p_valid_q))
    else $error("output word appeared without a product word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !ready_i) |=> (o_valid_q && $stable(pixel_q)
                                 && $stable(o_idx_q)))
    else $error("output word changed while stalled");
`endif

endmodule
`default_nettype wire

/* rtl/bilinear_downscale_pixel.sv */
`default_nettype none
// Throughput: one word per cycle unless the output stalls; input ready
//   stays high while any stage ahead is free, so bubbles are squeezed out under output stalls.
// Stages: position multiply, bilinear weights, channel products, sum/output.
// Reset: asynchronous, active low; clears valid bits, both steps to 1.0.
// ----------------------------------------------------------------------------
// Bilinear downscale pixel
// Maps a destination pixel to its source position with Q2.16 steps and
// blends the four neighbouring RGB888 source pixels.
// ----------------------------------------------------------------------------
module bilinear_downscale_pixel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bds_pkg::APB_AW-1:0]    paddr,
  input  wire logic [bds_pkg::APB_DW-1:0]    pwdata,
  output logic [bds_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bds_pkg::COORD_W-1:0]   dest_col_i,
  input  wire logic [bds_pkg::COORD_W-1:0]   dest_row_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_here_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_east_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_south_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_southeast_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bds_pkg::PIX_W-1:0]          blended_pixel_o,
  output logic [bds_pkg::SRC_W-1:0]          source_col_o,
  output logic [bds_pkg::SRC_W-1:0]          source_row_o
);
  import bds_pkg::*;

  logic [STEP_W-1:0]    step_x_q;
  logic [STEP_W-1:0]    step_y_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  logic                 s1_valid_q;
  logic                 s2_valid_q;
  logic                 s1_en;
  logic                 s2_en;
  logic                 blend_ready;

  logic [POS_W-1:0]     pos_x_d;
  logic [POS_W-1:0]     pos_y_d;
  logic [POS_W-1:0]     s1_pos_x_q;
  logic [POS_W-1:0]     s1_pos_y_q;
  pix_quad_t            s1_pix_q;

  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic [OMF_W-1:0]     omfx;
  logic [OMF_W-1:0]     omfy;
  wgt_t                 wgt_d;
  wgt_t                 s2_wgt_q;
  pix_quad_t            s2_pix_q;
  src_idx_t             idx_d;
  src_idx_t             s2_idx_q;
  src_idx_t             out_idx;

  // Config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= STEP_RESET;
      step_y_q <= STEP_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STEP_X: step_x_q <= pwdata[STEP_W-1:0];
        REG_STEP_Y: step_y_q <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEP_X: prdata = APB_DW'(step_x_q);
      REG_STEP_Y: prdata = APB_DW'(step_y_q);
      default:    prdata = '0;
    endcase
  end

  // Stall chain
  assign s2_en      = !s2_valid_q || blend_ready;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // Stage 1: source positions
  assign pos_x_d = POS_W'(dest_col_i) * POS_W'(step_x_q);
  assign pos_y_d = POS_W'(dest_row_i) * POS_W'(step_y_q);

  // Stage 2: weights
  assign fx   = s1_pos_x_q[FRAC_BITS-1:0];
  assign fy   = s1_pos_y_q[FRAC_BITS-1:0];
  assign omfx = ONE_Q - OMF_W'(fx);
  assign omfy = ONE_Q - OMF_W'(fy);

  assign wgt_d.southeast = WGT_W'(fx) * WGT_W'(fy);
  assign wgt_d.east      = WGT_W'(fx) * WGT_W'(omfy);
  assign wgt_d.south     = WGT_W'(fy) * WGT_W'(omfx);
  assign wgt_d.here      = WGT_W'(omfx) * WGT_W'(omfy);

  assign idx_d.col = s1_pos_x_q[FRAC_BITS +: SRC_W];
  assign idx_d.row = s1_pos_y_q[FRAC_BITS +: SRC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_pos_x_q         <= pos_x_d;
      s1_pos_y_q         <= pos_y_d;
      s1_pix_q.here      <= pixel_here_i;
      s1_pix_q.east      <= pixel_east_i;
      s1_pix_q.south     <= pixel_south_i;
      s1_pix_q.southeast <= pixel_southeast_i;
    end
    if (s2_en && s1_valid_q) begin
      s2_wgt_q <= wgt_d;
      s2_pix_q <= s1_pix_q;
      s2_idx_q <= idx_d;
    end
  end

  // Stages 3 and 4
  bds_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .ready_o (blend_ready),
    .wgt_i   (s2_wgt_q),
    .pix_i   (s2_pix_q),
    .idx_i   (s2_idx_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pixel_o (blended_pixel_o),
    .idx_o   (out_idx)
  );

  assign source_col_o = out_idx.col;
  assign source_row_o = out_idx.row;

`ifndef SYNTH
  a_wgt_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> ((WGT_W + 1)'(s2_wgt_q.here) + (WGT_W + 1)'(s2_wgt_q.east)
                    + (WGT_W + 1)'(s2_wgt_q.south)
                    + (WGT_W + 1)'(s2_wgt_q.southeast)) == ONE_SQ)
    else $error("bilinear weights do not sum to one");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_en) |=> (s1_valid_q && $stable(s1_pos_x_q)
                                && $stable(s1_pos_y_q)))
    else $error("position stage lost its word while stalled");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !blend_ready) |=> (s2_valid_q && $stable(s2_idx_q)))
    else $error("weight stage lost its word while stalled");
`endif

endmodule
`default_nettype wire
